/* rtl/heightmap_to_normal_map_macros.svh */
// Assertion macros used by the heightmap_to_normal_map top level.
// Expects clk and rst_n to be visible at the point of use.
`ifndef HEIGHTMAP_TO_NORMAL_MAP_MACROS_SVH
`define HEIGHTMAP_TO_NORMAL_MAP_MACROS_SVH

// Same-cycle implication.
`define HMN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HMN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hmn_pkg.sv */
// Package for the height-map to normal-map converter.
// Widths, constants and item types; no dependencies.
`default_nettype none

package hmn_pkg;

    localparam int SUM_W               = 10;
    localparam int NUM_SUMS            = 9;
    localparam int IN_DATA_W           = 96;
    localparam int OUT_W               = 8;
    localparam int OUT_DATA_W          = 32;
    localparam int SCALE_W             = 16;
    localparam int ACC_W               = 12;
    localparam int DIFF_W              = 13;
    localparam int PROD_W              = SCALE_W + DIFF_W;
    localparam int MAG_W               = 27;
    localparam int SLOPE_W             = 23;
    localparam int GRAD_SHIFT          = 8;
    localparam int GRAD_DIV            = 4590;
    localparam int GRAD_RCP_W          = 23;
    localparam int DPROD_W             = MAG_W + GRAD_RCP_W;
    localparam int DCHK_W              = SLOPE_W + 13;
    localparam int SQ_W                = 2 * SLOPE_W;
    localparam int ROOT_W              = SQ_W / 2;
    localparam int RREM_W              = ROOT_W + 3;
    localparam int RSQRT_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
    localparam int THIRD_MUL           = 683;
    localparam int THIRD_SHIFT         = 11;

    localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;
    localparam logic [SQ_W-1:0]           SQ_ONE      = SQ_W'(64'h1_0000_0000);
    localparam logic [ROOT_W-1:0]         RCP_REM0    = ROOT_W'(32'h8000);
    // floor(2^35 / GRAD_DIV); the estimate undershoots the quotient by at most one
    localparam logic [GRAD_RCP_W-1:0]     GRAD_RCP    = 23'd7485781;

    typedef struct packed {
        logic             sgn_u;
        logic             sgn_v;
        logic [MAG_W-1:0] mag_u;
        logic [MAG_W-1:0] mag_v;
        logic [OUT_W-1:0] alpha;
    } hmn_item_t;

    typedef struct packed {
        logic             sgn_u;
        logic             sgn_v;
        logic [OUT_W-1:0] alpha;
    } hmn_side_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hmn_qstat_t;

endpackage

`default_nettype wire

/* rtl/heightmap_to_normal_map.sv */
// Takes one 3x3 window of r+g+b height sums per transaction and returns one
// normal-map texel (red, green, blue, alpha) per transaction. One window is
// accepted every clock while m_tready stays high; the back pipeline carries a
// three-stage slope divide by reciprocal multiplication, a one-bit-per-stage
// square root and reciprocal: a 23-stage root and RSQRT_FRAC_BITS + 1
// reciprocal stages.
// Top level: instantiates hmn_front, hmn_queue and hmn_back; uses hmn_pkg
// and heightmap_to_normal_map_macros.svh.
`default_nettype none
`include "heightmap_to_normal_map_macros.svh"

module heightmap_to_normal_map
#(
    parameter int RSQRT_FRAC_BITS = hmn_pkg::RSQRT_FRAC_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hmn_pkg::SCALE_W-1:0]   cfg_data,   // height_scale
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // up_left_sum, up_sum, up_right_sum, left_sum, right_sum,
    // down_left_sum, down_sum, down_right_sum, centre_sum, 6'b0
    input  wire logic [hmn_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // normal_red, normal_green, normal_blue, height_alpha
    output logic [hmn_pkg::OUT_DATA_W-1:0]     m_tdata
);

    hmn_pkg::hmn_qstat_t q_stat;
    hmn_pkg::hmn_item_t  q_in_item, q_head_item;
    logic                q_push, q_pop;

    hmn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_item (q_in_item)
    );

    hmn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .stat      (q_stat)
    );

    hmn_back #(.RSQRT_FRAC_BITS(RSQRT_FRAC_BITS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_item  (q_head_item),
        .pop     (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

    `HMN_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "push into full queue")
    `HMN_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty, "pop from empty queue")
    `HMN_ASSERT_NOW(a_blue_floor, m_tvalid, m_tdata[23:16] >= 8'd127, "blue below bias")
    `HMN_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full, "full queue drained")

endmodule

`default_nettype wire

/* rtl/hmn_queue.sv */
// Short queue between the front and back parts of the converter.
// Depends on hmn_pkg for the item type and depth.
`default_nettype none

module hmn_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hmn_pkg::hmn_item_t push_item,
    input  wire logic              pop,
    output hmn_pkg::hmn_item_t     head_item,
    output hmn_pkg::hmn_qstat_t    stat
);

    hmn_pkg::hmn_item_t             mem [0:hmn_pkg::QUEUE_DEPTH-1];
    logic [hmn_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hmn_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hmn_pkg::QPTR_W:0]       cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    assign head_item  = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (hmn_pkg::QPTR_W+1)'(hmn_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

/* rtl/hmn_front.sv */
// Front part: accepts windows, forms the scaled gradients and the alpha value.
// Depends on hmn_pkg; feeds hmn_queue.
`default_nettype none

module hmn_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hmn_pkg::SCALE_W-1:0]   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hmn_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire hmn_pkg::hmn_qstat_t           q_stat,
    output logic                               push,
    output hmn_pkg::hmn_item_t                 push_item
);

    logic signed [hmn_pkg::SCALE_W-1:0] scale_reg;
    logic                               fr_vld_reg, fr_vld_next;
    hmn_pkg::hmn_item_t                 fr_item_reg, fr_item_next;

    logic [hmn_pkg::SUM_W-1:0]          ul, up, ur, lf, rt, dl, dn, dr, ce;
    logic [hmn_pkg::ACC_W-1:0]          col_l, col_r, row_t, row_b;
    logic signed [hmn_pkg::DIFF_W-1:0]  du, dv;
    logic signed [hmn_pkg::PROD_W-1:0]  pu, pv, nu, nv;
    logic [hmn_pkg::SUM_W+hmn_pkg::THIRD_SHIFT:0] third;
    logic [hmn_pkg::SUM_W-1:0]          alpha_w;
    logic                               accept;

    assign cfg_ready = 1'b1;

    assign ul = s_tdata[9:0];
    assign up = s_tdata[19:10];
    assign ur = s_tdata[29:20];
    assign lf = s_tdata[39:30];
    assign rt = s_tdata[49:40];
    assign dl = s_tdata[59:50];
    assign dn = s_tdata[69:60];
    assign dr = s_tdata[79:70];
    assign ce = s_tdata[89:80];

    assign s_tready = !fr_vld_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = fr_vld_reg && !q_stat.full;
    assign push_item = fr_item_reg;

    always_comb
    begin
        col_l = hmn_pkg::ACC_W'(ul) + hmn_pkg::ACC_W'(lf) + hmn_pkg::ACC_W'(dl);
        col_r = hmn_pkg::ACC_W'(ur) + hmn_pkg::ACC_W'(rt) + hmn_pkg::ACC_W'(dr);
        row_t = hmn_pkg::ACC_W'(ul) + hmn_pkg::ACC_W'(up) + hmn_pkg::ACC_W'(ur);
        row_b = hmn_pkg::ACC_W'(dl) + hmn_pkg::ACC_W'(dn) + hmn_pkg::ACC_W'(dr);
        du    = $signed({1'b0, col_r}) - $signed({1'b0, col_l});
        dv    = $signed({1'b0, row_b}) - $signed({1'b0, row_t});
        pu    = scale_reg * du;
        pv    = scale_reg * dv;
        nu    = -pu;
        nv    = -pv;
        third = (hmn_pkg::SUM_W+hmn_pkg::THIRD_SHIFT+1)'(ce) *
                (hmn_pkg::SUM_W+hmn_pkg::THIRD_SHIFT+1)'(hmn_pkg::THIRD_MUL);
        alpha_w = hmn_pkg::SUM_W'(third >> hmn_pkg::THIRD_SHIFT);

        fr_item_next.sgn_u = pu[hmn_pkg::PROD_W-1];
        fr_item_next.sgn_v = pv[hmn_pkg::PROD_W-1];
        fr_item_next.mag_u = pu[hmn_pkg::PROD_W-1] ? nu[hmn_pkg::MAG_W-1:0]
                                                   : pu[hmn_pkg::MAG_W-1:0];
        fr_item_next.mag_v = pv[hmn_pkg::PROD_W-1] ? nv[hmn_pkg::MAG_W-1:0]
                                                   : pv[hmn_pkg::MAG_W-1:0];
        fr_item_next.alpha = (alpha_w > hmn_pkg::SUM_W'(255)) ? 8'hFF
                                                              : alpha_w[hmn_pkg::OUT_W-1:0];

        fr_vld_next = fr_vld_reg;
        if (accept)
            fr_vld_next = 1'b1;
        else if (push)
            fr_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= hmn_pkg::SCALE_RESET;
            fr_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                scale_reg <= cfg_data;
            fr_vld_reg <= fr_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fr_item_reg <= fr_item_next;
    end

endmodule

`default_nettype wire

/* rtl/hmn_back.sv */
// Back part: slope divide, magnitude square root, reciprocal and channel mapping.
// Depends on hmn_pkg; drains hmn_queue.
`default_nettype none

module hmn_back
#(
    parameter int RSQRT_FRAC_BITS = hmn_pkg::RSQRT_FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hmn_pkg::hmn_qstat_t        q_stat,
    input  wire hmn_pkg::hmn_item_t         q_item,
    output logic                            pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [hmn_pkg::OUT_DATA_W-1:0]  m_data
);

    localparam int DS     = hmn_pkg::SLOPE_W;
    localparam int DQ     = 2;
    localparam int RS     = hmn_pkg::ROOT_W;
    localparam int CS     = RSQRT_FRAC_BITS + 1;
    localparam int RCP_W  = RSQRT_FRAC_BITS + 1;
    localparam int MP_W   = hmn_pkg::SLOPE_W + RCP_W;
    localparam int TILT_W = MP_W + 1;
    localparam int BS_W   = RSQRT_FRAC_BITS + 2;
    localparam int BM_W   = BS_W + 8;
    localparam int TOT    = DQ + RS + CS + 7;
    localparam int RT0    = DQ + 2;
    localparam int RC0    = RT0 + RS + 1;
    localparam int MUL_ST = RC0 + CS + 1;
    localparam logic signed [TILT_W-1:0] TILT_BASE = TILT_W'(1) << (16 + RSQRT_FRAC_BITS);
    localparam logic [BS_W-1:0]          BLUE_BASE = BS_W'(1) << RSQRT_FRAC_BITS;

    logic                                adv;
    logic [TOT-1:0]                      vld_reg;
    hmn_pkg::hmn_side_t                  side_reg [0:TOT-1];

    logic [hmn_pkg::MAG_W-1:0]           dq_mu0_reg, dq_mv0_reg;
    logic [hmn_pkg::MAG_W-1:0]           dq_mu1_reg, dq_mv1_reg;
    logic [DS-1:0]                       dq_qu1_reg, dq_qv1_reg;
    logic [DS-1:0]                       dq_qu2_reg, dq_qv2_reg;
    logic [hmn_pkg::DPROD_W-1:0]         dq_pu, dq_pv;
    logic [hmn_pkg::DCHK_W-1:0]          dq_ru, dq_rv;

    logic [hmn_pkg::SQ_W-1:0]            sq_u_reg, sq_v_reg;
    logic [DS-1:0]                       sq_mu_reg, sq_mv_reg;

    logic [hmn_pkg::RREM_W-1:0]          rt_rem_reg [0:RS];
    logic [RS-1:0]                       rt_root_reg [0:RS];
    logic [hmn_pkg::SQ_W-1:0]            rt_val_reg [0:RS];
    logic [DS-1:0]                       rt_mu_reg [0:RS];
    logic [DS-1:0]                       rt_mv_reg [0:RS];

    logic [RS-1:0]                       rc_rem_reg [0:CS];
    logic [RS-1:0]                       rc_m_reg [0:CS];
    logic [RCP_W-1:0]                    rc_quo_reg [0:CS];
    logic [DS-1:0]                       rc_mu_reg [0:CS];
    logic [DS-1:0]                       rc_mv_reg [0:CS];

    logic [MP_W-1:0]                     mp_u_reg, mp_v_reg;
    logic [hmn_pkg::OUT_W-1:0]           mp_blue_reg, tl_blue_reg;
    logic signed [TILT_W-1:0]            tl_u_reg, tl_v_reg;
    logic [hmn_pkg::OUT_W-1:0]           out_red_reg, out_green_reg, out_blue_reg;

    logic [BS_W-1:0]                     blue_sum;
    logic [BM_W-1:0]                     blue_mul, blue_shr;

    function automatic logic [hmn_pkg::OUT_W-1:0] tilt_chan(input logic signed [TILT_W-1:0] t);
        logic [TILT_W+7:0] tu;
        logic [TILT_W+7:0] n;
        logic [TILT_W+7:0] v;
        tu = (TILT_W+8)'(unsigned'(t));
        n  = (tu << 8) - tu;
        v  = n >> (17 + RSQRT_FRAC_BITS);
        if (t[TILT_W-1])
            tilt_chan = '0;
        else if (v > (TILT_W+8)'(255))
            tilt_chan = 8'hFF;
        else
            tilt_chan = v[hmn_pkg::OUT_W-1:0];
    endfunction

    assign adv     = !vld_reg[TOT-1] || m_ready;
    assign pop     = adv && !q_stat.empty;
    assign m_valid = vld_reg[TOT-1];
    assign m_data  = {side_reg[TOT-1].alpha, out_blue_reg, out_green_reg, out_red_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOT-2:0], !q_stat.empty};
    end

    always_comb
    begin
        dq_pu = dq_mu0_reg * hmn_pkg::GRAD_RCP;
        dq_pv = dq_mv0_reg * hmn_pkg::GRAD_RCP;
        dq_ru = (hmn_pkg::DCHK_W'(dq_mu1_reg) << hmn_pkg::GRAD_SHIFT) -
                dq_qu1_reg * hmn_pkg::DCHK_W'(hmn_pkg::GRAD_DIV);
        dq_rv = (hmn_pkg::DCHK_W'(dq_mv1_reg) << hmn_pkg::GRAD_SHIFT) -
                dq_qv1_reg * hmn_pkg::DCHK_W'(hmn_pkg::GRAD_DIV);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].sgn_u <= q_item.sgn_u;
            side_reg[0].sgn_v <= q_item.sgn_v;
            side_reg[0].alpha <= q_item.alpha;
            for (int k = 1; k < TOT; k++)
                side_reg[k] <= side_reg[k-1];

            dq_mu0_reg <= q_item.mag_u;
            dq_mv0_reg <= q_item.mag_v;

            dq_mu1_reg <= dq_mu0_reg;
            dq_mv1_reg <= dq_mv0_reg;
            dq_qu1_reg <= dq_pu[hmn_pkg::DPROD_W-1 -: DS];
            dq_qv1_reg <= dq_pv[hmn_pkg::DPROD_W-1 -: DS];

            dq_qu2_reg <= (dq_ru >= hmn_pkg::DCHK_W'(hmn_pkg::GRAD_DIV)) ? dq_qu1_reg + 1'b1
                                                                         : dq_qu1_reg;
            dq_qv2_reg <= (dq_rv >= hmn_pkg::DCHK_W'(hmn_pkg::GRAD_DIV)) ? dq_qv1_reg + 1'b1
                                                                         : dq_qv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_u_reg  <= dq_qu2_reg * dq_qu2_reg;
            sq_v_reg  <= dq_qv2_reg * dq_qv2_reg;
            sq_mu_reg <= dq_qu2_reg;
            sq_mv_reg <= dq_qv2_reg;

            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_val_reg[0]  <= sq_u_reg + sq_v_reg + hmn_pkg::SQ_ONE;
            rt_mu_reg[0]   <= sq_mu_reg;
            rt_mv_reg[0]   <= sq_mv_reg;
        end
    end

    for (genvar i = 1; i <= RS; i++)
    begin : g_root
        logic [hmn_pkg::RREM_W-1:0] sh, trial;
        logic                       ge;
        assign sh    = {rt_rem_reg[i-1][hmn_pkg::RREM_W-3:0],
                        rt_val_reg[i-1][hmn_pkg::SQ_W-1 -: 2]};
        assign trial = hmn_pkg::RREM_W'({rt_root_reg[i-1], 2'b01});
        assign ge    = (sh >= trial);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_rem_reg[i]  <= ge ? sh - trial : sh;
                rt_root_reg[i] <= {rt_root_reg[i-1][RS-2:0], ge};
                rt_val_reg[i]  <= rt_val_reg[i-1] << 2;
                rt_mu_reg[i]   <= rt_mu_reg[i-1];
                rt_mv_reg[i]   <= rt_mv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rc_rem_reg[0] <= hmn_pkg::RCP_REM0;
            rc_m_reg[0]   <= rt_root_reg[RS];
            rc_quo_reg[0] <= '0;
            rc_mu_reg[0]  <= rt_mu_reg[RS];
            rc_mv_reg[0]  <= rt_mv_reg[RS];
        end
    end

    for (genvar i = 1; i <= CS; i++)
    begin : g_rcp
        logic [RS:0] t, md;
        logic        ge;
        assign t  = {rc_rem_reg[i-1], 1'b0};
        assign md = {1'b0, rc_m_reg[i-1]};
        assign ge = (t >= md);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rc_rem_reg[i] <= ge ? RS'(t - md) : RS'(t);
                rc_m_reg[i]   <= rc_m_reg[i-1];
                rc_quo_reg[i] <= {rc_quo_reg[i-1][RCP_W-2:0], ge};
                rc_mu_reg[i]  <= rc_mu_reg[i-1];
                rc_mv_reg[i]  <= rc_mv_reg[i-1];
            end
        end
    end

    always_comb
    begin
        blue_sum = BLUE_BASE + BS_W'(rc_quo_reg[CS]);
        blue_mul = (BM_W'(blue_sum) << 8) - BM_W'(blue_sum);
        blue_shr = blue_mul >> (RSQRT_FRAC_BITS + 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_u_reg    <= rc_mu_reg[CS] * rc_quo_reg[CS];
            mp_v_reg    <= rc_mv_reg[CS] * rc_quo_reg[CS];
            mp_blue_reg <= (blue_shr > BM_W'(255)) ? 8'hFF : blue_shr[hmn_pkg::OUT_W-1:0];

            tl_u_reg    <= side_reg[MUL_ST].sgn_u ? TILT_BASE + $signed({1'b0, mp_u_reg})
                                                  : TILT_BASE - $signed({1'b0, mp_u_reg});
            tl_v_reg    <= side_reg[MUL_ST].sgn_v ? TILT_BASE + $signed({1'b0, mp_v_reg})
                                                  : TILT_BASE - $signed({1'b0, mp_v_reg});
            tl_blue_reg <= mp_blue_reg;

            out_red_reg   <= tilt_chan(tl_u_reg);
            out_green_reg <= tilt_chan(tl_v_reg);
            out_blue_reg  <= tl_blue_reg;
        end
    end

endmodule

`default_nettype wire
